/* sv/hsc_pkg.sv */
// shared constants, codes and parity helpers of the secded codec
package hsc_pkg;

  localparam int CODE_BITS  = 21;
  localparam int SYN_BITS   = 5;
  localparam int DATA_BITS  = CODE_BITS - SYN_BITS;
  localparam int WORD_BITS  = CODE_BITS + 1;
  localparam int STATUS_W   = 2;

  localparam logic [SYN_BITS-1:0] SYN_MAX = SYN_BITS'(CODE_BITS);

  // operation codes
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_CLEAN  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_SINGLE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DOUBLE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd3;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [DATA_BITS-1:0]  data_t;
  typedef logic [SYN_BITS-1:0]   syn_t;

  function automatic logic is_pow2(int p);
    return (p & (p - 1)) == 0;
  endfunction

  // data bits go to positions that are not powers of two, lowest first
  function automatic word_t scatter_data(data_t d);
    word_t w;
    int    k;
    w = '0;
    k = 0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (!is_pow2(p)) begin
        w[p] = d[k];
        k++;
      end
    end
    return w;
  endfunction

  function automatic data_t extract_data(word_t w);
    data_t d;
    int    k;
    d = '0;
    k = 0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if (!is_pow2(p)) begin
        d[k] = w[p];
        k++;
      end
    end
    return d;
  endfunction

  // bit c is the parity of all positions whose index has bit c set
  function automatic syn_t check_parity(word_t w);
    syn_t s;
    s = '0;
    for (int c = 0; c < SYN_BITS; c++) begin
      for (int p = 1; p <= CODE_BITS; p++) begin
        if (((p >> c) & 1) == 1) begin
          s[c] = s[c] ^ w[p];
        end
      end
    end
    return s;
  endfunction

endpackage

/* sv/hamming_secded_codec_core.sv */
// secded (22,16) encoder and checker/corrector, three register stages
//
//  channel  valid         stall         beat fields
//  -------  ------------  ------------  -----------------------------------------------
//  in       in_valid_i    in_stall_o    operation_i, data_word_i, code_word_i
//  out      out_valid_o   out_stall_i   encoded_word_o, decoded_data_o, syndrome_o, status_o
//
// a beat passes three register stages from input to output register: input capture, parity trees,
// then overall parity or status and correction. a new beat enters every cycle while in_stall_o is low.
// reset clears the three stage valid bits only. a stall holds only stages that are
// full and blocked, so bubbles close up; in_stall_o rises when all three stages are full
// and out_stall_i is high.
module hamming_secded_codec_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  hsc_pkg::data_t                 data_word_i,
  input  hsc_pkg::word_t                 code_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hsc_pkg::word_t                 encoded_word_o,
  output hsc_pkg::data_t                 decoded_data_o,
  output hsc_pkg::syn_t                  syndrome_o,
  output logic [hsc_pkg::STATUS_W-1:0]   status_o
);
  import hsc_pkg::*;

  // stage 1: input capture
  logic  s1_valid_q;
  logic  s1_op_q;
  data_t s1_data_q;
  word_t s1_code_q;

  // stage 2: parity trees
  logic  s2_valid_q;
  logic  s2_op_q;
  word_t s2_word_q, s2_word_d;
  syn_t  s2_syn_q,  s2_syn_d;
  logic  s2_par_q,  s2_par_d;

  // stage 3: output register
  logic                s3_valid_q;
  word_t               s3_enc_q,  s3_enc_d;
  data_t               s3_data_q, s3_data_d;
  syn_t                s3_syn_q,  s3_syn_d;
  logic [STATUS_W-1:0] s3_stat_q, s3_stat_d;

  logic  s1_load, s2_load, s3_load;
  word_t enc_pkt;
  syn_t  enc_chk;
  word_t fixed_word;

  assign s3_load    = !s3_valid_q || !out_stall_i;
  assign s2_load    = !s2_valid_q || s3_load;
  assign s1_load    = !s1_valid_q || s2_load;
  assign in_stall_o = !s1_load;

  // encode: data scattered, check bits at power-of-two positions, bit 0 left for later
  always_comb begin
    enc_pkt = scatter_data(s1_data_q);
    enc_chk = check_parity(enc_pkt);
    for (int c = 0; c < SYN_BITS; c++) begin
      enc_pkt[1 << c] = enc_chk[c];
    end
  end

  always_comb begin
    if (s1_op_q == OP_ENCODE) begin
      s2_word_d = enc_pkt;
      s2_syn_d  = '0;
      s2_par_d  = 1'b0;
    end else begin
      s2_word_d = s1_code_q;
      s2_syn_d  = check_parity(s1_code_q);
      s2_par_d  = ^s1_code_q;
    end
  end

  always_comb begin
    fixed_word = s2_word_q;
    s3_enc_d   = '0;
    s3_data_d  = '0;
    s3_syn_d   = '0;
    s3_stat_d  = STAT_CLEAN;
    if (s2_op_q == OP_ENCODE) begin
      s3_enc_d = {s2_word_q[WORD_BITS-1:1], ^s2_word_q[WORD_BITS-1:1]};
    end else begin
      s3_syn_d = s2_syn_q;
      if (s2_syn_q != '0 && !s2_par_q) begin
        s3_stat_d = STAT_DOUBLE;
      end else if (s2_syn_q == '0 && !s2_par_q) begin
        s3_stat_d = STAT_CLEAN;
      end else if (s2_syn_q == '0) begin
        // only the overall parity bit flipped
        s3_stat_d = STAT_SINGLE;
      end else if (s2_syn_q <= SYN_MAX) begin
        fixed_word = s2_word_q ^ (WORD_BITS'(1) << s2_syn_q);
        s3_stat_d  = STAT_SINGLE;
      end else begin
        s3_stat_d = STAT_RANGE;
      end
      s3_data_d = extract_data(fixed_word);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_load) s1_valid_q <= in_valid_i;
      if (s2_load) s2_valid_q <= s1_valid_q;
      if (s3_load) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_op_q   <= operation_i;
      s1_data_q <= data_word_i;
      s1_code_q <= code_word_i;
    end
    if (s2_load && s1_valid_q) begin
      s2_op_q   <= s1_op_q;
      s2_word_q <= s2_word_d;
      s2_syn_q  <= s2_syn_d;
      s2_par_q  <= s2_par_d;
    end
    if (s3_load && s2_valid_q) begin
      s3_enc_q  <= s3_enc_d;
      s3_data_q <= s3_data_d;
      s3_syn_q  <= s3_syn_d;
      s3_stat_q <= s3_stat_d;
    end
  end

  assign out_valid_o    = s3_valid_q;
  assign encoded_word_o = s3_enc_q;
  assign decoded_data_o = s3_data_q;
  assign syndrome_o     = s3_syn_q;
  assign status_o       = s3_stat_q;

endmodule

/* tb/sv/hsc_codec_checker.sv */
// channel monitor, secded result calculation and beat-by-beat comparison
`timescale 1ns / 1ps

module hsc_codec_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         operation_i,
  input  hsc_pkg::data_t               data_word_i,
  input  hsc_pkg::word_t               code_word_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  hsc_pkg::word_t               encoded_word_i,
  input  hsc_pkg::data_t               decoded_data_i,
  input  hsc_pkg::syn_t                syndrome_i,
  input  logic [hsc_pkg::STATUS_W-1:0] status_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import hsc_pkg::*;

  typedef struct packed {
    word_t               enc;
    data_t               dec;
    syn_t                syn;
    logic [STATUS_W-1:0] stat;
  } codec_res_t;

  codec_res_t queued_results[$];
  int         mismatches = 0;

  // bit p of the word holds code position p, bit 0 the overall parity
  function automatic word_t encode_data(data_t d);
    word_t w;
    int    k;
    logic  par;
    w = '0;
    k = 0;
    for (int p = 1; p <= CODE_BITS; p++) begin
      if ((p & (p - 1)) != 0) begin
        w[p] = d[k];
        k++;
      end
    end
    for (int c = 0; c < SYN_BITS; c++) begin
      par = 1'b0;
      for (int p = 1; p <= CODE_BITS; p++) begin
        if (((p >> c) & 1) == 1) par = par ^ w[p];
      end
      w[1 << c] = par;
    end
    w[0] = ^w[CODE_BITS:1];
    return w;
  endfunction

  function automatic codec_res_t secded_result(logic op, data_t d, word_t cw);
    codec_res_t r;
    word_t      w;
    syn_t       s;
    logic       par;
    int         k;
    r = '0;
    if (op == OP_ENCODE) begin
      r.enc = encode_data(d);
    end else begin
      w = cw;
      s = '0;
      for (int c = 0; c < SYN_BITS; c++) begin
        for (int p = 1; p <= CODE_BITS; p++) begin
          if (((p >> c) & 1) == 1) s[c] = s[c] ^ w[p];
        end
      end
      par = ^w;
      // even parity with a nonzero syndrome wins over everything else
      if (s != '0 && !par) begin
        r.stat = STAT_DOUBLE;
      end else if (s == '0 && !par) begin
        r.stat = STAT_CLEAN;
      end else if (s == '0) begin
        r.stat = STAT_SINGLE;
      end else if (s <= SYN_MAX) begin
        w[s]   = ~w[s];
        r.stat = STAT_SINGLE;
      end else begin
        r.stat = STAT_RANGE;
      end
      k = 0;
      for (int p = 1; p <= CODE_BITS; p++) begin
        if ((p & (p - 1)) != 0) begin
          r.dec[k] = w[p];
          k++;
        end
      end
      r.syn = s;
    end
    return r;
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    codec_res_t head;
    if (rst_ni) begin
      // pop before push so a spurious beat never meets its own input
      if (out_valid_i && !out_stall_i) begin
        if (queued_results.size() == 0) begin
          $display("%0t: output beat with nothing outstanding, expected none, actual %h %h %h %h",
                   $time, encoded_word_i, decoded_data_i, syndrome_i, status_i);
          mismatches++;
        end else begin
          head = queued_results.pop_front();
          cmp_field("encoded_word", 32'(head.enc), 32'(encoded_word_i));
          cmp_field("decoded_data", 32'(head.dec), 32'(decoded_data_i));
          cmp_field("syndrome", 32'(head.syn), 32'(syndrome_i));
          cmp_field("status", 32'(head.stat), 32'(status_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        queued_results.push_back(secded_result(operation_i, data_word_i, code_word_i));
      end
    end
    pending_o    <= queued_results.size();
    fail_count_o <= mismatches;
  end

endmodule

/* tb/sv/tb_hamming_secded_codec_core.sv */
// stimulus, clock, reset and final verdict for the secded codec core
`timescale 1ns / 1ps

module tb_hamming_secded_codec_core;
  import hsc_pkg::*;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                operation    = OP_ENCODE;
  data_t               data_word    = '0;
  word_t               code_word    = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  word_t               encoded_word;
  data_t               decoded_data;
  syn_t                syndrome;
  logic [STATUS_W-1:0] status;
  int                  fail_count;
  int                  pending;

  int                  stall_cyc    = 0;
  int                  stall_mode   = 0;

  hamming_secded_codec_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .data_word_i   (data_word),
    .code_word_i   (code_word),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .encoded_word_o(encoded_word),
    .decoded_data_o(decoded_data),
    .syndrome_o    (syndrome),
    .status_o      (status)
  );

  hsc_codec_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .operation_i   (operation),
    .data_word_i   (data_word),
    .code_word_i   (code_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .encoded_word_i(encoded_word),
    .decoded_data_i(decoded_data),
    .syndrome_i    (syndrome),
    .status_i      (status),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stall pattern follows a stall mode that is redrawn at random as stall_cyc counts
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_cyc % 3 == 0);
    endcase
  end

  task automatic drive_beat(input logic op, input data_t d, input word_t c, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    data_word <= d;
    code_word <= c;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic word_t bit_mask(int b);
    return word_t'(1) << b;
  endfunction

  initial begin
    word_t clean;
    word_t cw;
    data_t dw;
    logic  op;
    int    burst_left;
    int    gap;
    int    b0;
    int    b1;
    int    b2;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and each decode outcome
    drive_beat(OP_ENCODE, 16'h0000, '0, 0);
    drive_beat(OP_ENCODE, 16'hFFFF, '0, 0);
    drive_beat(OP_ENCODE, 16'h0001, '1, 1);
    drive_beat(OP_ENCODE, 16'h8000, '0, 0);
    drive_beat(OP_ENCODE, 16'hA5A5, '1, 0);
    drive_beat(OP_DECODE, '0, '0, 2);
    drive_beat(OP_DECODE, '1, '1, 0);
    clean = u_check.encode_data(16'h1234);
    drive_beat(OP_DECODE, '0, clean, 0);
    // overall parity bit flipped
    drive_beat(OP_DECODE, '0, clean ^ bit_mask(0), 0);
    drive_beat(OP_DECODE, '0, clean ^ bit_mask(3), 1);
    drive_beat(OP_DECODE, '0, clean ^ bit_mask(16), 0);
    drive_beat(OP_DECODE, '0, clean ^ bit_mask(21), 0);
    // double errors, one of them on the parity bit
    drive_beat(OP_DECODE, '0, clean ^ bit_mask(5) ^ bit_mask(9), 0);
    drive_beat(OP_DECODE, '0, clean ^ bit_mask(0) ^ bit_mask(7), 3);
    // three flips whose indices xor past the last position
    drive_beat(OP_DECODE, '0, clean ^ bit_mask(2) ^ bit_mask(4) ^ bit_mask(16), 0);
    drive_beat(OP_DECODE, '0, clean ^ bit_mask(16) ^ bit_mask(8) ^ bit_mask(7), 0);
    clean = u_check.encode_data(16'hFFFF);
    drive_beat(OP_DECODE, 16'hFFFF, clean, 0);
    drive_beat(OP_DECODE, '0, clean ^ bit_mask(1), 0);
    drain_results();

    burst_left = 0;
    for (int n = 0; n < 1300; n++) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 32);
      end else begin
        gap = 0;
      end
      burst_left--;

      dw = data_t'($urandom());
      cw = word_t'($urandom());
      op = ($urandom_range(0, 9) < 4) ? OP_ENCODE : OP_DECODE;
      if (op == OP_DECODE) begin
        clean = u_check.encode_data(data_t'($urandom()));
        b0    = $urandom_range(0, WORD_BITS - 1);
        b1    = (b0 + $urandom_range(1, WORD_BITS - 1)) % WORD_BITS;
        b2    = $urandom_range(0, WORD_BITS - 1);
        case ($urandom_range(0, 9))
          0, 1:    cw = clean;
          2, 3, 4: cw = clean ^ bit_mask(b0);
          5, 6:    cw = clean ^ bit_mask(b0) ^ bit_mask(b1);
          7:       cw = clean ^ bit_mask(b0) ^ bit_mask(b1) ^ bit_mask(b2);
          default: cw = word_t'($urandom());
        endcase
      end
      drive_beat(op, dw, cw, gap);

      // sender holds off until the pipe is empty
      if (n == 650) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
